// ===== hdl/html_entity_decoder_unit_defines.svh =====
// Assertion macros shared by the character reference decoder modules.
`ifndef HTML_ENTITY_DECODER_UNIT_DEFINES_SVH
`define HTML_ENTITY_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HED_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define HED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define HED_ASSERT(label, clk, rst_n, prop, msg)

`define HED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/hed_pkg.sv =====
// Shared types, constants and lookup functions of the character reference decoder.
`default_nettype none

package hed_pkg;

  localparam int HED_MAX_HELD = 16;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_XLO  = 8'h78;
  localparam logic [7:0] CH_XUP  = 8'h58;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_ONE_MAX = 21'h00007F;
  localparam logic [20:0] CP_TWO_MAX = 21'h0007FF;
  localparam logic [20:0] CP_THR_MAX = 21'h00FFFF;

  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;

  localparam int NUM_NAMES = 6;

  typedef enum logic [2:0] {
    ACT_PASS  = 3'd0,
    ACT_HOLD  = 3'd1,
    ACT_NAMED = 3'd2,
    ACT_UTF8  = 3'd3,
    ACT_FAIL  = 3'd4,
    ACT_BARE  = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    SEL_INPUT = 3'd0,
    SEL_NAMED = 3'd1,
    SEL_UTF   = 3'd2,
    SEL_HELD  = 3'd3,
    SEL_TAIL  = 3'd4,
    SEL_BARE  = 3'd5
  } sel_e;

  typedef struct packed {
    act_e act;
    logic out_free;
    logic flush_last;
    logic utf_last;
    logic tail_amp;
    logic tail_end;
  } dp_status_t;

  typedef struct packed {
    logic take;
    logic load;
    sel_e sel;
    logic last;
    logic tend;
    logic utf_adv;
    logic flush_adv;
    logic finish;
    logic restart;
  } dp_cmd_t;

  function automatic logic [2:0] name_size(input logic [2:0] k);
    logic [2:0] len;
    case (k)
      3'd0:    len = 3'd3;
      3'd1:    len = 3'd2;
      3'd2:    len = 3'd2;
      3'd3:    len = 3'd4;
      3'd4:    len = 3'd4;
      3'd5:    len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_result(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'h26;
      3'd1:    r = 8'h3C;
      3'd2:    r = 8'h3E;
      3'd3:    r = 8'h22;
      3'd4:    r = 8'h27;
      3'd5:    r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Characters of amp, lt, gt, quot, apos and nbsp by name and position.
  function automatic logic [7:0] name_char(input logic [2:0] k, input logic [1:0] p);
    logic [31:0] txt;
    case (k)
      3'd0:    txt = 32'h00_70_6D_61;
      3'd1:    txt = 32'h00_00_74_6C;
      3'd2:    txt = 32'h00_00_74_67;
      3'd3:    txt = 32'h74_6F_75_71;
      3'd4:    txt = 32'h73_6F_70_61;
      3'd5:    txt = 32'h70_73_62_6E;
      default: txt = 32'h0;
    endcase
    return txt[{p, 3'b000} +: 8];
  endfunction

  // Returns the digit value in the low four bits and a valid flag on top.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      d = {1'b1, 4'(c - 8'h57)};
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      d = {1'b1, 4'(c - 8'h37)};
    end
    return d;
  endfunction

  function automatic logic [1:0] utf8_len(input logic [20:0] cp);
    logic [1:0] n;
    if (cp <= CP_ONE_MAX) begin
      n = 2'd0;
    end else if (cp <= CP_TWO_MAX) begin
      n = 2'd1;
    end else if (cp <= CP_THR_MAX) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte idx of the UTF-8 form of cp, where len is the byte count minus one.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: begin
        case (idx)
          2'd0:    b = UTF_LEAD2 | {3'b0, cp[10:6]};
          default: b = UTF_CONT | {2'b0, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = UTF_LEAD3 | {4'b0, cp[15:12]};
          2'd1:    b = UTF_CONT | {2'b0, cp[11:6]};
          default: b = UTF_CONT | {2'b0, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = UTF_LEAD4 | {5'b0, cp[20:18]};
          2'd1:    b = UTF_CONT | {2'b0, cp[17:12]};
          2'd2:    b = UTF_CONT | {2'b0, cp[11:6]};
          default: b = UTF_CONT | {2'b0, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/html_entity_decoder_unit.sv =====
// Top level of the streaming HTML character reference decoder.
//
// The slave channel takes one text byte per beat in tdata; a beat with tlast high is
// an end-of-text marker whose data is ignored. Each beat yields zero or more master
// beats carrying one output byte each; tlast marks the last beat caused by an input
// beat, tuser[0] says the byte is real (low only for an end marker with nothing
// held) and tuser[1] marks the final beat of the text.
// Plain bytes and the first byte of a reference are accepted in the run state, so text
// without references streams at one byte per cycle through the output register while
// the receiver does not stall. A completed named reference loads its result on the
// ';' beat; a numeric one accepts the ';' and then emits its UTF-8 bytes (1 to 4). A
// failed reference accepts the failing beat, then replays its N held bytes from the
// held byte memory at one per cycle while the receiver does not stall, and last the
// failing byte when it is passed through.
// After reset the decoder is idle with nothing held. When the receiver stalls, the
// output register holds its beat and no input is accepted until it can be loaded.
`default_nettype none

module html_entity_decoder_unit import hed_pkg::*; #(
  parameter int MAX_HELD = HED_MAX_HELD
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  wire logic       s_axis_tlast,   // end_mark
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] text_end
  output logic            m_axis_tlast    // run_last
);

  dp_status_t status;
  dp_cmd_t    cmd;
  logic       bvalid, tend;

  hed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hed_datapath #(
    .MAX_HELD (MAX_HELD)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .out_bvalid_o (bvalid),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (tend)
  );

  assign m_axis_tuser = {tend, bvalid};

endmodule

`default_nettype wire

// ===== hdl/hed_datapath.sv =====
// Datapath of the decoder: parse state, held byte memory, UTF-8 encoder and output register.
`default_nettype none
`include "html_entity_decoder_unit_defines.svh"

module hed_datapath import hed_pkg::*; #(
  parameter int MAX_HELD = HED_MAX_HELD
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_end_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_status_t      status_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            out_bvalid_o,
  output logic            out_last_o,
  output logic            out_end_o
);

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int IW = $clog2(MAX_HELD);

  typedef enum logic [4:0] {
    M_IDLE     = 5'b00001,
    M_NAME     = 5'b00010,
    M_NUMSTART = 5'b00100,
    M_DEC      = 5'b01000,
    M_HEX      = 5'b10000
  } mode_e;

  mode_e                     mode_q, mode_n;
  logic [CW-1:0]             count_q;
  logic [20:0]               code_q, code_n;
  logic                      digit_q, digit_n;
  logic [NUM_NAMES-1:0]      cand_q, cand_n;
  logic [CW-1:0]             ptr_q;
  logic [1:0]                uidx_q, ulen_q;
  logic [7:0]                tail_byte_q;
  logic                      tail_end_q;
  logic [7:0]                mem [MAX_HELD];
  logic [7:0]                rd_data_q;

  act_e                      act;
  logic [7:0]                named_res;
  logic [CW-1:0]             pos;
  logic                      hold_ok;
  logic                      is_hex;
  logic [4:0]                dig;
  logic [24:0]               scaled;
  logic [24:0]               next_val;
  logic                      surrogate;
  logic                      named_hit;
  logic [NUM_NAMES-1:0]      keep;
  act_e                      num_act;

  logic                      we;
  logic [IW-1:0]             waddr;
  logic [7:0]                wdata;
  logic [CW-1:0]             raddr_full;

  logic                      out_valid_q;
  logic [7:0]                out_byte_q;
  logic                      out_bvalid_q, out_last_q, out_end_q;
  logic [7:0]                sel_byte;

  assign pos       = count_q - 1'b1;
  assign hold_ok   = count_q < CW'(MAX_HELD);
  assign is_hex    = (mode_q == M_HEX);
  assign dig       = digit_value(in_byte_i, is_hex);
  assign scaled    = is_hex ? {code_q, 4'b0000}
                            : ({1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0});
  assign next_val  = scaled + {21'b0, dig[3:0]};
  assign surrogate = (code_q >= CP_SUR_LO) && (code_q <= CP_SUR_HI);

  always_comb begin
    keep      = '0;
    named_hit = 1'b0;
    named_res = 8'h00;
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      if (cand_q[k]) begin
        if (pos == CW'(name_size(3'(k)))) begin
          named_hit = 1'b1;
          named_res = name_result(3'(k));
        end
        if (pos < CW'(name_size(3'(k))) && name_char(3'(k), pos[1:0]) == in_byte_i) begin
          keep[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    num_act = ACT_FAIL;
    if (in_byte_i == CH_SEMI) begin
      num_act = (digit_q && !surrogate) ? ACT_UTF8 : ACT_FAIL;
    end else if (dig[4] && next_val <= {4'b0, CP_MAX} && hold_ok) begin
      num_act = ACT_HOLD;
    end
  end

  always_comb begin
    act     = ACT_FAIL;
    mode_n  = mode_q;
    cand_n  = cand_q;
    code_n  = code_q;
    digit_n = digit_q;
    if (in_end_i) begin
      act = (count_q == '0) ? ACT_BARE : ACT_FAIL;
    end else begin
      case (mode_q)
        M_NAME: begin
          if (pos == '0 && in_byte_i == CH_HASH) begin
            act    = hold_ok ? ACT_HOLD : ACT_FAIL;
            mode_n = M_NUMSTART;
          end else if (in_byte_i == CH_SEMI) begin
            act = named_hit ? ACT_NAMED : ACT_FAIL;
          end else begin
            act    = (keep != '0 && hold_ok) ? ACT_HOLD : ACT_FAIL;
            cand_n = keep;
          end
        end
        M_NUMSTART: begin
          if (in_byte_i == CH_XLO || in_byte_i == CH_XUP) begin
            act    = hold_ok ? ACT_HOLD : ACT_FAIL;
            mode_n = M_HEX;
          end else begin
            act     = num_act;
            mode_n  = M_DEC;
            code_n  = next_val[20:0];
            digit_n = 1'b1;
          end
        end
        M_DEC, M_HEX: begin
          act     = num_act;
          code_n  = next_val[20:0];
          digit_n = 1'b1;
        end
        default: begin
          if (in_byte_i == CH_AMP) begin
            act     = ACT_HOLD;
            mode_n  = M_NAME;
            cand_n  = '1;
            code_n  = '0;
            digit_n = 1'b0;
          end else begin
            act = ACT_PASS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      count_q <= '0;
      code_q  <= '0;
      digit_q <= 1'b0;
      cand_q  <= '1;
      ptr_q   <= '0;
      uidx_q  <= '0;
    end else begin
      if (cmd_i.finish) begin
        mode_q  <= cmd_i.restart ? M_NAME : M_IDLE;
        count_q <= cmd_i.restart ? CW'(1) : '0;
        code_q  <= '0;
        digit_q <= 1'b0;
        cand_q  <= '1;
        ptr_q   <= '0;
        uidx_q  <= '0;
      end else begin
        if (cmd_i.take && act == ACT_HOLD) begin
          mode_q  <= mode_n;
          count_q <= count_q + 1'b1;
          code_q  <= code_n;
          digit_q <= digit_n;
          cand_q  <= cand_n;
        end else if (cmd_i.take && act == ACT_NAMED) begin
          mode_q  <= M_IDLE;
          count_q <= '0;
          code_q  <= '0;
          digit_q <= 1'b0;
          cand_q  <= '1;
        end
        if (cmd_i.utf_adv) begin
          uidx_q <= uidx_q + 1'b1;
        end
        if (cmd_i.flush_adv) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && act == ACT_UTF8) begin
      ulen_q <= utf8_len(code_q);
    end
    if (cmd_i.take && act == ACT_FAIL) begin
      tail_byte_q <= in_byte_i;
      tail_end_q  <= in_end_i;
    end
  end

  always_comb begin
    we    = (cmd_i.take && act == ACT_HOLD) || cmd_i.restart;
    waddr = cmd_i.restart ? '0 : count_q[IW-1:0];
    wdata = cmd_i.restart ? CH_AMP : in_byte_i;
  end

  assign raddr_full = cmd_i.flush_adv ? ptr_q + 1'b1 : ptr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr_full[IW-1:0]];
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_INPUT: sel_byte = in_byte_i;
      SEL_NAMED: sel_byte = named_res;
      SEL_UTF:   sel_byte = utf8_byte(code_q, ulen_q, uidx_q);
      SEL_HELD:  sel_byte = rd_data_q;
      SEL_TAIL:  sel_byte = tail_byte_q;
      default:   sel_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q   <= sel_byte;
      out_bvalid_q <= (cmd_i.sel != SEL_BARE);
      out_last_q   <= cmd_i.last;
      out_end_q    <= cmd_i.tend;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_bvalid_o = out_bvalid_q;
  assign out_last_o   = out_last_q;
  assign out_end_o    = out_end_q;

  always_comb begin
    status_o.act        = act;
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.flush_last = (ptr_q + 1'b1) == count_q;
    status_o.utf_last   = (uidx_q == ulen_q);
    status_o.tail_amp   = (tail_byte_q == CH_AMP);
    status_o.tail_end   = tail_end_q;
  end

  `HED_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_HELD), "held count above bound")
  `HED_ASSERT(a_idle_empty, clk_i, rst_ni, (count_q == '0) == (mode_q == M_IDLE), "idle mismatch")
  `HED_ASSERT_IMP(a_flush_range, clk_i, rst_ni, cmd_i.flush_adv, ptr_q < count_q, "replay past end")

endmodule

`default_nettype wire

// ===== hdl/hed_ctrl.sv =====
// Controller state machine that sequences acceptance, UTF-8 emission and held byte replay.
`default_nettype none
`include "html_entity_decoder_unit_defines.svh"

module hed_ctrl import hed_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_UTF   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.take        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.sel         = SEL_INPUT;
    cmd_o.last        = 1'b0;
    cmd_o.tend        = 1'b0;
    cmd_o.utf_adv     = 1'b0;
    cmd_o.flush_adv   = 1'b0;
    cmd_o.finish      = 1'b0;
    cmd_o.restart     = 1'b0;
    case (state_q)
      ST_RUN: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.take = 1'b1;
          case (status_i.act)
            ACT_PASS: begin
              cmd_o.load = 1'b1;
              cmd_o.sel  = SEL_INPUT;
              cmd_o.last = 1'b1;
            end
            ACT_NAMED: begin
              cmd_o.load = 1'b1;
              cmd_o.sel  = SEL_NAMED;
              cmd_o.last = 1'b1;
            end
            ACT_BARE: begin
              cmd_o.load = 1'b1;
              cmd_o.sel  = SEL_BARE;
              cmd_o.last = 1'b1;
              cmd_o.tend = 1'b1;
            end
            ACT_UTF8: state_d = ST_UTF;
            ACT_FAIL: state_d = ST_FLUSH;
            default: ;
          endcase
        end
      end
      ST_UTF: begin
        if (status_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.sel     = SEL_UTF;
          cmd_o.last    = status_i.utf_last;
          cmd_o.utf_adv = 1'b1;
          if (status_i.utf_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_RUN;
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.sel       = SEL_HELD;
          cmd_o.flush_adv = 1'b1;
          if (status_i.flush_last) begin
            cmd_o.finish  = 1'b1;
            cmd_o.last    = status_i.tail_end || status_i.tail_amp;
            cmd_o.tend    = status_i.tail_end;
            cmd_o.restart = status_i.tail_amp && !status_i.tail_end;
            state_d       = (status_i.tail_end || status_i.tail_amp) ? ST_RUN : ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = SEL_TAIL;
          cmd_o.last = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  `HED_ASSERT_IMP(a_run_load, clk_i, rst_ni, state_q == ST_RUN && cmd_o.load, in_fire, "beat loaded without an accepted item")
  `HED_ASSERT_IMP(a_finish_beat, clk_i, rst_ni, cmd_o.finish, cmd_o.load && (cmd_o.utf_adv || cmd_o.flush_adv), "sequence finished without a beat")
  `HED_ASSERT_IMP(a_ready_run, clk_i, rst_ni, in_ready_o, state_q == ST_RUN && status_i.out_free, "input ready outside the accept state")

endmodule

`default_nettype wire
